/* src/lru_replacement_top_defines.svh */
// ----------------------------------------------------------------------------
// lru_replacement_top_defines
// Assertion macros used by the LRU replacement checker.
// ----------------------------------------------------------------------------
`ifndef LRU_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_REPLACEMENT_TOP_DEFINES_SVH

// same-cycle implication
`define LRU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lru_pkg.sv */
// ----------------------------------------------------------------------------
// lru_pkg
// Types and constants for the LRU replacement block.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_W           = 8;
    localparam int CAP_W           = 5;
    localparam int CNT_W           = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

    // broadcast to every cell for one beat
    typedef struct packed {
        logic             en;
        logic             hit;
        logic             evict;
        logic [KEY_W-1:0] key;
    } t_cell_cmd;

    // per-cell position flags decoded from occupancy
    typedef struct packed {
        logic valid;
        logic last;
        logic append;
    } t_cell_ctl;

endpackage

/* src/lru_cell.sv */
// ----------------------------------------------------------------------------
// lru_cell
// One slot of the recency chain: holds a key, compares it to the request
// and takes its neighbor's key when the chain shifts toward slot 0.
// ----------------------------------------------------------------------------
module lru_cell (
    input  logic                      i_clk,
    input  lru_pkg::t_cell_cmd        i_cmd,
    input  lru_pkg::t_cell_ctl        i_ctl,
    input  logic [lru_pkg::KEY_W-1:0] i_next_key,
    input  logic                      i_prefix,
    output logic [lru_pkg::KEY_W-1:0] o_key,
    output logic                      o_prefix
);
    import lru_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             w_match;

    assign w_match  = i_ctl.valid & (r_key == i_cmd.key);
    assign o_prefix = i_prefix | w_match;
    assign o_key    = r_key;

    always_comb begin
        n_key = r_key;
        if (i_cmd.en) begin
            if (i_cmd.hit || i_cmd.evict) begin
                if (i_ctl.last) begin
                    n_key = i_cmd.key;
                end else if (i_ctl.valid && (o_prefix || i_cmd.evict)) begin
                    n_key = i_next_key;
                end
            end else if (i_ctl.append) begin
                n_key = i_cmd.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

/* src/lru_replacement_top.sv */
// ----------------------------------------------------------------------------
// lru_replacement_top: fully associative LRU cache, one key per beat
// Result is registered in the cycle after the beat; 1 beat per cycle while no
// stalled result holds the input, set by the compare and shift across the cells.
// Synchronous active-low reset empties the cache, clears the hit count, capacity 4.
// ----------------------------------------------------------------------------
module lru_replacement_top #(
    parameter int MAX_ENTRIES = lru_pkg::MAX_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lru_pkg::CAP_W-1:0] i_cfg_capacity,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [lru_pkg::KEY_W-1:0] i_request_key,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_hit,
    output logic                      o_evicted,
    output logic [lru_pkg::KEY_W-1:0] o_evicted_key,
    output logic [lru_pkg::CNT_W-1:0] o_hit_total
);
    import lru_pkg::*;

    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0] r_capacity;
    logic [OCC_W-1:0] r_occ;
    logic [CNT_W-1:0] r_hit_count;
    logic [CNT_W-1:0] n_hit_count;
    logic             r_out_valid;
    logic             r_hit;
    logic             r_evicted;
    logic [KEY_W-1:0] r_evicted_key;

    logic             w_accept;
    logic             w_hit;
    logic             w_full;
    logic             w_evict;
    logic [CMP_W-1:0] w_cap_eff;
    t_cell_cmd        w_cmd;

    logic [MAX_ENTRIES:0]   w_prefix;
    logic [KEY_W-1:0]       w_key [MAX_ENTRIES];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;

    always_comb begin
        if (r_capacity == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(MAX_ENTRIES)) begin
            w_cap_eff = CMP_W'(MAX_ENTRIES);
        end else begin
            w_cap_eff = CMP_W'(r_capacity);
        end
    end

    assign w_hit   = w_prefix[MAX_ENTRIES];
    assign w_full  = CMP_W'(r_occ) >= w_cap_eff;
    assign w_evict = ~w_hit & w_full;

    assign w_cmd.en    = w_accept;
    assign w_cmd.hit   = w_hit;
    assign w_cmd.evict = w_evict;
    assign w_cmd.key   = i_request_key;

    assign w_prefix[0] = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_cell_ctl        w_ctl;
        logic [KEY_W-1:0] w_next;

        assign w_ctl.valid  = OCC_W'(g) < r_occ;
        assign w_ctl.last   = OCC_W'(g + 1) == r_occ;
        assign w_ctl.append = OCC_W'(g) == r_occ;

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_key[g + 1];
        end

        lru_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_ctl      (w_ctl),
            .i_next_key (w_next),
            .i_prefix   (w_prefix[g]),
            .o_key      (w_key[g]),
            .o_prefix   (w_prefix[g + 1])
        );
    end

    always_comb begin
        n_hit_count = r_hit_count;
        if (w_accept && w_hit && (r_hit_count != '1)) begin
            n_hit_count = r_hit_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_occ       <= '0;
            r_hit_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_capacity;
            end
            if (w_accept && !w_hit && !w_full) begin
                r_occ <= r_occ + OCC_W'(1);
            end
            r_hit_count <= n_hit_count;
            if (!o_in_stall) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit         <= w_hit;
            r_evicted     <= w_evict;
            r_evicted_key <= w_evict ? w_key[0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;
    assign o_hit_total   = r_hit_count;

endmodule

/* src/lru_chk.sv */
// ----------------------------------------------------------------------------
// lru_chk
// Port-level checks for lru_replacement_top, attached by bind.
// ----------------------------------------------------------------------------
`include "lru_replacement_top_defines.svh"

module lru_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_hit,
    input logic                      o_evicted,
    input logic [lru_pkg::KEY_W-1:0] o_evicted_key,
    input logic [lru_pkg::CNT_W-1:0] o_hit_total
);

    // input only backs up behind a held result
    `LRU_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stall without held result")

    `LRU_ASSERT_NOW(a_hit_no_evict, i_clk, i_rst_n, o_out_valid && o_evicted, !o_hit, "eviction reported on a hit")

    `LRU_ASSERT_NOW(a_evkey_zero, i_clk, i_rst_n, o_out_valid && !o_evicted, o_evicted_key == '0, "evicted key nonzero without eviction")

    // hit total moves only with an input beat
    `LRU_ASSERT_NEXT(a_total_hold, i_clk, i_rst_n, !(i_in_valid && !o_in_stall), $stable(o_hit_total), "hit total changed without input beat")

    `LRU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_hit) && $stable(o_evicted_key), "stalled result changed")

endmodule

bind lru_replacement_top lru_chk u_lru_chk (.*);

/* sim/tb_lru_replacement_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_replacement_top
// Self-checking bench for the fully associative LRU cache. A local model of
// the resident key order, occupancy and hit count predicts every result beat.
// Checks are field by field, in order. Capacity is swept over its range,
// including zero, the clamped upper values and a drop below the occupancy.
// Random keys come from a small sliding window to get hits, plus full-range
// keys. Random stalls run on both sides, and one long receiver hold-off
// backs the block up.
// ----------------------------------------------------------------------------
module tb_lru_replacement_top;

    localparam int DEPTH = lru_pkg::MAX_ENTRIES_DEF;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        bit                      hit;
        bit                      evicted;
        bit [lru_pkg::KEY_W-1:0] evicted_key;
        bit [lru_pkg::CNT_W-1:0] hit_total;
    } t_lookup_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [lru_pkg::CAP_W-1:0] i_cfg_capacity = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [lru_pkg::KEY_W-1:0] i_request_key = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_hit;
    logic                      o_evicted;
    logic [lru_pkg::KEY_W-1:0] o_evicted_key;
    logic [lru_pkg::CNT_W-1:0] o_hit_total;

    bit [lru_pkg::KEY_W-1:0] cache_keys[DEPTH];
    int                      resident = 0;
    bit [lru_pkg::CNT_W-1:0] hits_seen = '0;
    bit [lru_pkg::CAP_W-1:0] cap_setting = lru_pkg::CAP_RESET;

    t_lookup_result expected_lookups[$];
    int error_count = 0;
    bit tx_idling = 1'b0;
    bit rx_idling = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int stall_left = 0;

    lru_replacement_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_request_key  (i_request_key),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_evicted_key  (o_evicted_key),
        .o_hit_total    (o_hit_total)
    );

    always #10 i_clk = ~i_clk;

    function automatic int effective_capacity();
        if (cap_setting == 0) return 1;
        if (cap_setting > DEPTH) return DEPTH;
        return int'(cap_setting);
    endfunction

    function automatic t_lookup_result predict_lookup(input bit [lru_pkg::KEY_W-1:0] key);
        t_lookup_result r;
        bit found;
        int pos;
        r = '{default: 0};
        found = 1'b0;
        pos = 0;
        for (int i = 0; i < resident; i++) begin
            if (!found && cache_keys[i] == key) begin
                found = 1'b1;
                pos = i;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            if (hits_seen != '1) hits_seen++;
        end
        if (found || resident >= effective_capacity()) begin
            if (!found) begin
                r.evicted = 1'b1;
                r.evicted_key = cache_keys[0];
            end
            for (int i = pos; i + 1 < resident; i++) cache_keys[i] = cache_keys[i + 1];
            cache_keys[resident - 1] = key;
        end else begin
            cache_keys[resident] = key;
            resident++;
        end
        r.hit_total = hits_seen;
        return r;
    endfunction

    task automatic send_key(input bit [lru_pkg::KEY_W-1:0] key);
        if (tx_idling && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_request_key <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_lookups.insert(expected_lookups.size(), predict_lookup(key));
    endtask

    task automatic drain_lookups();
        i_in_valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input bit [lru_pkg::CAP_W-1:0] value);
        drain_lookups();
        i_cfg_valid <= 1'b1;
        i_cfg_capacity <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cap_setting = value;
    endtask

    task automatic run_lookups(input int count);
        bit [lru_pkg::KEY_W-1:0] base;
        bit [lru_pkg::KEY_W-1:0] key;
        base = 8'($urandom_range(0, 255));
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 49) base = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 4) == 0)
                key = 8'($urandom_range(0, 255));
            else
                key = base + 8'($urandom_range(0, effective_capacity() + 2));
            send_key(key);
        end
    endtask

    task automatic test_reset_capacity();
        send_key(8'h00);
        send_key(8'hFF);
        send_key(8'h00);
        send_key(8'hAA);
        send_key(8'h55);
        send_key(8'h12);
        send_key(8'hFF);
    endtask

    task automatic test_capacity_extremes();
        write_capacity(5'd0);
        send_key(8'h07);
        send_key(8'h07);
        send_key(8'h08);
        write_capacity(5'd31);
        for (int k = 0; k < DEPTH + 1; k++) send_key(8'(8'h80 + k));
        // occupancy stays at the built depth while capacity drops under it
        write_capacity(5'd2);
        send_key(8'h85);
        send_key(8'h3C);
        send_key(8'h8F);
    endtask

    task automatic test_backpressure();
        bit keep_tx;
        keep_tx = tx_idling;
        tx_idling = 1'b0;
        hold_requests++;
        run_lookups(60);
        tx_idling = keep_tx;
    endtask

    task automatic test_random_traffic();
        bit [lru_pkg::CAP_W-1:0] cap_plan[9] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd3,
                                                  5'd8, 5'd0, 5'd2, 5'd17};
        for (int p = 0; p < 9; p++) begin
            write_capacity(p == 6 ? 5'($urandom_range(0, 31)) : cap_plan[p]);
            if (p == 8) begin
                tx_idling = 1'b0;
                rx_idling = 1'b0;
            end
            run_lookups(195);
            if (p == 3) test_backpressure();
        end
    endtask

    // receiver stall, random bursts plus the requested long hold-off
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left = HOLD_CYCLES;
        end else if (stall_left == 0 && rx_idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_lookup_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_lookups.size() == 0) begin
                $error("result beat with no lookup pending");
                error_count++;
            end else begin
                want = expected_lookups.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, o_hit);
                    error_count++;
                end
                if (o_evicted !== want.evicted) begin
                    $error("evicted: expected %0d actual %0d", want.evicted, o_evicted);
                    error_count++;
                end
                if (o_evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected %0h actual %0h",
                           want.evicted_key, o_evicted_key);
                    error_count++;
                end
                if (o_hit_total !== want.hit_total) begin
                    $error("hit_total: expected %0d actual %0d", want.hit_total, o_hit_total);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_capacity();
        test_capacity_extremes();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        test_random_traffic();
        drain_lookups();
        if (expected_lookups.size() != 0) begin
            $error("%0d lookups never answered", expected_lookups.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb_lru_replacement_top OK");
        else
            $display("tb_lru_replacement_top NOT OK");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_lru_replacement_top NOT OK");
        $finish;
    end

endmodule
